// ===== rtl/leg_throttle_scheduler_top_defines.svh =====
// assertion macros used by lts_core in the rtl of the leg throttle scheduler
`ifndef LEG_THROTTLE_SCHEDULER_TOP_DEFINES_SVH
`define LEG_THROTTLE_SCHEDULER_TOP_DEFINES_SVH

// checked on every clock edge outside reset
`define LTS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define LTS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== rtl/lts_pkg.sv =====
// types, constants and codes of the leg throttle scheduler
`timescale 1ns / 1ps

package lts_pkg;

   localparam int RANGE_W  = 24;
   localparam int TAG_W    = 32;
   localparam int THR_W    = 16;
   localparam int THR_FRAC = 15;
   localparam int METRE_W  = 25;
   localparam int PROD_W   = 35;
   localparam int SUM_W    = 29;
   localparam int DIV_W    = 45;
   localparam int QUO_W    = 25;
   localparam int STEP_W   = 5;

   // quotient bits produced for each division
   localparam int R_STEPS = 25;
   localparam int T_STEPS = 15;
   localparam int N_STEPS = 15;

   localparam logic [10:0] MILLI_NM_TO_M = 11'd1852;
   localparam logic [9:0]  M_PER_KM      = 10'd1000;

   localparam logic [METRE_W-1:0] SHORT_LEG_M = METRE_W'(150);
   localparam logic [METRE_W-1:0] RAMP_LEG_M  = METRE_W'(900);

   localparam logic [THR_W-1:0] Q_ONE       = THR_W'(32768);
   localparam logic [THR_W-1:0] Q_SHORT_LEG = THR_W'(4915);
   localparam logic [THR_W-1:0] Q_MIN_THR   = THR_W'(3277);

   // divisors pre-aligned to the top quotient bit
   localparam logic [DIV_W-1:0] R_DIVISOR = DIV_W'(M_PER_KM) << (R_STEPS - 1);
   localparam logic [DIV_W-1:0] T_DIVISOR = DIV_W'(RAMP_LEG_M) << (T_STEPS - 1);

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b000_0000_0001,
      ST_MUL_R  = 11'b000_0000_0010,
      ST_DIV_R  = 11'b000_0000_0100,
      ST_WAIT_R = 11'b000_0000_1000,
      ST_BASE   = 11'b000_0001_0000,
      ST_WAIT_T = 11'b000_0010_0000,
      ST_BRAKE  = 11'b000_0100_0000,
      ST_MUL_N  = 11'b000_1000_0000,
      ST_DIV_N  = 11'b001_0000_0000,
      ST_WAIT_N = 11'b010_0000_0000,
      ST_DONE   = 11'b100_0000_0000
   } state_type;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  dividend;
      logic [DIV_W-1:0]  divisor;
      logic [STEP_W-1:0] steps;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic [THR_W-1:0] throttle;
      logic             engines_set;
      logic             leg_zero;
   } result_type;

endpackage

// ===== rtl/lts_if.sv =====
// channel interfaces of the leg throttle scheduler
`timescale 1ns / 1ps

interface lts_req_if;
   logic                        valid;
   logic                        ready;
   logic [lts_pkg::RANGE_W-1:0] range_milli_nm;
   logic [lts_pkg::TAG_W-1:0]   waypoint_tag;

   modport source (output valid, output range_milli_nm, output waypoint_tag, input ready);
   modport sink   (input valid, input range_milli_nm, input waypoint_tag, output ready);
endinterface

interface lts_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [lts_pkg::THR_W-1:0] throttle;
   logic                      engines_set;
   logic                      leg_zero;

   modport source (output valid, output throttle, output engines_set, output leg_zero,
                   input ready);
   modport sink   (input valid, input throttle, input engines_set, input leg_zero,
                   output ready);
endinterface

interface lts_csr_if;
   logic valid;
   logic ready;
   logic enable;

   modport source (output valid, output enable, input ready);
   modport sink   (input valid, input enable, output ready);
endinterface

// ===== rtl/leg_throttle_scheduler_top.sv =====
// top level of the leg throttle scheduler
//
//  channel  | dir | beat contents                              | handshake
//  req_ch   | in  | range_milli_nm, waypoint_tag               | valid / ready
//  rsp_ch   | out | throttle, engines_set, leg_zero            | valid / ready
//  csr_ch   | in  | enable                                     | valid / ready, always ready
//
// one request beat at a time; ready is high only while the sequencer is idle
// enabled: each beat runs its divisions on the shared bit-serial divider
//   (25 quotient bits for metres, 15 for the ramp throttle, 15 for braking)
// disabled: an all-zero response, stored leg and waypoint tag untouched
// the response register holds a finished beat, so the next request is taken
//   while rsp_ch stalls; reset is synchronous, active high, and clears the control state and the stored leg
`timescale 1ns / 1ps

module leg_throttle_scheduler_top (
   input  logic             clock,
   input  logic             reset,
   lts_req_if.sink          req_ch,
   lts_rsp_if.source        rsp_ch,
   lts_csr_if.sink          csr_ch
);

   logic                 enable_ff, enable_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   lts_pkg::result_type  rsp_ff, rsp_in;
   logic                 res_valid;
   logic                 res_take;
   lts_pkg::result_type  res;
   lts_pkg::div_req_type div_req;
   lts_pkg::div_rsp_type div_rsp;

   lts_core u_core (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable_ff),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_range  (req_ch.range_milli_nm),
      .in_tag    (req_ch.waypoint_tag),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res       (res),
      .div_req   (div_req),
      .div_rsp   (div_rsp)
   );

   lts_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // output slot free or being emptied this cycle
   assign res_take = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      enable_in    = enable_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (csr_ch.valid) begin
         enable_in = csr_ch.enable;
      end
      if (res_valid && res_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         enable_ff    <= enable_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign csr_ch.ready       = 1'b1;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.throttle    = rsp_ff.throttle;
   assign rsp_ch.engines_set = rsp_ff.engines_set;
   assign rsp_ch.leg_zero    = rsp_ff.leg_zero;

endmodule

// ===== rtl/lts_div.sv =====
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module lts_div (
   input  logic                 clock,
   input  logic                 reset,
   input  lts_pkg::div_req_type div_req,
   output lts_pkg::div_rsp_type div_rsp
);

   logic [lts_pkg::DIV_W-1:0]  rem_ff, rem_in;
   logic [lts_pkg::DIV_W-1:0]  dvs_ff, dvs_in;
   logic [lts_pkg::QUO_W-1:0]  quo_ff, quo_in;
   logic [lts_pkg::STEP_W-1:0] cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [lts_pkg::DIV_W:0]    diff;
   logic                       fits;

   always_comb begin
      diff    = {1'b0, rem_ff} - {1'b0, dvs_ff};
      fits    = ~diff[lts_pkg::DIV_W];
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
         quo_in  = '0;
         cnt_in  = div_req.steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = diff[lts_pkg::DIV_W-1:0];
         end
         quo_in = {quo_ff[lts_pkg::QUO_W-2:0], fits};
         dvs_in = dvs_ff >> 1;
         cnt_in = cnt_ff - lts_pkg::STEP_W'(1);
         if (cnt_ff == lts_pkg::STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== rtl/lts_core.sv =====
// sequencer and datapath registers of the leg throttle scheduler
`timescale 1ns / 1ps
`include "leg_throttle_scheduler_top_defines.svh"

module lts_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        enable,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [lts_pkg::RANGE_W-1:0] in_range,
   input  logic [lts_pkg::TAG_W-1:0]   in_tag,
   output logic                        res_valid,
   input  logic                        res_take,
   output lts_pkg::result_type         res,
   output lts_pkg::div_req_type        div_req,
   input  lts_pkg::div_rsp_type        div_rsp
);

   lts_pkg::state_type          state_ff, state_in;
   logic [lts_pkg::RANGE_W-1:0] range_ff, range_in;
   logic [lts_pkg::TAG_W-1:0]   tag_ff, tag_in;
   logic [lts_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [lts_pkg::METRE_W-1:0] r_ff, r_in;
   logic [lts_pkg::METRE_W-1:0] leg_ff, leg_in;
   logic [lts_pkg::TAG_W-1:0]   stored_tag_ff, stored_tag_in;
   logic                        tag_valid_ff, tag_valid_in;
   logic [lts_pkg::THR_W-1:0]   t_ff, t_in;
   logic [lts_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic [lts_pkg::DIV_W-1:0]   num_ff, num_in;
   lts_pkg::result_type         res_ff, res_in;

   always_comb begin
      state_in      = state_ff;
      range_in      = range_ff;
      tag_in        = tag_ff;
      prod_in       = prod_ff;
      r_in          = r_ff;
      leg_in        = leg_ff;
      stored_tag_in = stored_tag_ff;
      tag_valid_in  = tag_valid_ff;
      t_in          = t_ff;
      sum_in        = sum_ff;
      num_in        = num_ff;
      res_in        = res_ff;
      div_req       = '0;
      in_ready      = 1'b0;
      res_valid     = 1'b0;
      case (state_ff)
         lts_pkg::ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               range_in = in_range;
               tag_in   = in_tag;
               if (enable) begin
                  state_in = lts_pkg::ST_MUL_R;
               end else begin
                  res_in   = '0;
                  state_in = lts_pkg::ST_DONE;
               end
            end
         end
         lts_pkg::ST_MUL_R: begin
            prod_in  = lts_pkg::PROD_W'(range_ff) * lts_pkg::PROD_W'(lts_pkg::MILLI_NM_TO_M);
            state_in = lts_pkg::ST_DIV_R;
         end
         lts_pkg::ST_DIV_R: begin
            div_req.start    = 1'b1;
            div_req.dividend = lts_pkg::DIV_W'(prod_ff);
            div_req.divisor  = lts_pkg::R_DIVISOR;
            div_req.steps    = lts_pkg::STEP_W'(lts_pkg::R_STEPS);
            state_in         = lts_pkg::ST_WAIT_R;
         end
         lts_pkg::ST_WAIT_R: begin
            if (div_rsp.done) begin
               r_in = div_rsp.quotient;
               // new waypoint: latch the leg
               if (!tag_valid_ff || tag_ff != stored_tag_ff) begin
                  leg_in        = div_rsp.quotient;
                  stored_tag_in = tag_ff;
                  tag_valid_in  = 1'b1;
               end
               state_in = lts_pkg::ST_BASE;
            end
         end
         lts_pkg::ST_BASE: begin
            if (leg_ff == '0) begin
               res_in.throttle    = '0;
               res_in.engines_set = 1'b0;
               res_in.leg_zero    = 1'b1;
               state_in           = lts_pkg::ST_DONE;
            end else if (leg_ff < lts_pkg::SHORT_LEG_M) begin
               t_in     = lts_pkg::Q_SHORT_LEG;
               state_in = lts_pkg::ST_BRAKE;
            end else if (leg_ff < lts_pkg::RAMP_LEG_M) begin
               div_req.start    = 1'b1;
               div_req.dividend = lts_pkg::DIV_W'(leg_ff) << lts_pkg::THR_FRAC;
               div_req.divisor  = lts_pkg::T_DIVISOR;
               div_req.steps    = lts_pkg::STEP_W'(lts_pkg::T_STEPS);
               state_in         = lts_pkg::ST_WAIT_T;
            end else begin
               t_in     = lts_pkg::Q_ONE;
               state_in = lts_pkg::ST_BRAKE;
            end
         end
         lts_pkg::ST_WAIT_T: begin
            if (div_rsp.done) begin
               t_in     = div_rsp.quotient[lts_pkg::THR_W-1:0];
               state_in = lts_pkg::ST_BRAKE;
            end
         end
         lts_pkg::ST_BRAKE: begin
            // last quarter of the leg: 4*r < leg
            if ({r_ff, 2'b00} < {2'b00, leg_ff}) begin
               sum_in = lts_pkg::SUM_W'(leg_ff) + lts_pkg::SUM_W'({r_ff, 5'b0})
                      + lts_pkg::SUM_W'({r_ff, 2'b0});
               state_in = lts_pkg::ST_MUL_N;
            end else begin
               res_in.throttle    = t_ff;
               res_in.engines_set = 1'b1;
               res_in.leg_zero    = 1'b0;
               state_in           = lts_pkg::ST_DONE;
            end
         end
         lts_pkg::ST_MUL_N: begin
            num_in   = lts_pkg::DIV_W'(t_ff) * lts_pkg::DIV_W'(sum_ff);
            state_in = lts_pkg::ST_DIV_N;
         end
         lts_pkg::ST_DIV_N: begin
            // divisor is 10 * leg aligned to the top quotient bit
            div_req.start    = 1'b1;
            div_req.dividend = num_ff;
            div_req.divisor  = (lts_pkg::DIV_W'(leg_ff) << (lts_pkg::N_STEPS + 2))
                             + (lts_pkg::DIV_W'(leg_ff) << lts_pkg::N_STEPS);
            div_req.steps    = lts_pkg::STEP_W'(lts_pkg::N_STEPS);
            state_in         = lts_pkg::ST_WAIT_N;
         end
         lts_pkg::ST_WAIT_N: begin
            if (div_rsp.done) begin
               if (div_rsp.quotient < lts_pkg::QUO_W'(lts_pkg::Q_MIN_THR)) begin
                  res_in.throttle = lts_pkg::Q_MIN_THR;
               end else begin
                  res_in.throttle = div_rsp.quotient[lts_pkg::THR_W-1:0];
               end
               res_in.engines_set = 1'b1;
               res_in.leg_zero    = 1'b0;
               state_in           = lts_pkg::ST_DONE;
            end
         end
         lts_pkg::ST_DONE: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = lts_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lts_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lts_pkg::ST_IDLE;
         leg_ff        <= '0;
         stored_tag_ff <= '0;
         tag_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         leg_ff        <= leg_in;
         stored_tag_ff <= stored_tag_in;
         tag_valid_ff  <= tag_valid_in;
      end
      range_ff <= range_in;
      tag_ff   <= tag_in;
      prod_ff  <= prod_in;
      r_ff     <= r_in;
      t_ff     <= t_in;
      sum_ff   <= sum_in;
      num_ff   <= num_in;
      res_ff   <= res_in;
   end

   assign res = res_ff;

   `LTS_ASSERT(a_start_idle_div, div_req.start |-> !div_rsp.busy, "divider restarted while busy")
   `LTS_ASSERT(a_done_waiting, div_rsp.done |-> (state_ff == lts_pkg::ST_WAIT_R || state_ff == lts_pkg::ST_WAIT_T || state_ff == lts_pkg::ST_WAIT_N), "divider finished with no one waiting")
   `LTS_ASSERT(a_tag_latched, (state_ff == lts_pkg::ST_WAIT_R && div_rsp.done) |=> tag_valid_ff, "waypoint tag not held after range conversion")
   `LTS_ASSERT(a_flags_excl, res_valid |-> !(res_ff.engines_set && res_ff.leg_zero), "command given on a zero leg")
   `LTS_ASSERT(a_thr_span, (res_valid && res_ff.engines_set) |-> (res_ff.throttle >= lts_pkg::Q_MIN_THR && res_ff.throttle <= lts_pkg::Q_ONE), "commanded throttle out of span")

endmodule
